>>> rtl/vdi_pkg.sv
// Shared constants and the control bundle for the vertex dedup indexer.
package vdi_pkg;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int INDEX_WIDTH      = 8;

	typedef struct packed {
		logic at_end;
		logic fin_ok;
	} cell_ctrl_t;

endpackage

>>> rtl/vertex_dedup_indexer.sv
// Vertex dedup indexer top level: query register, search cursor, entry count and result register.
//
// Each accepted vertex beat is looked up in a chain of MAX_VERTICES cells, each
// holding one distinct vertex of the current mesh. A search token enters cell 0
// the cycle after the beat is accepted and moves one cell per cycle until it
// finds a matching entry or reaches the first unused cell, where the vertex is
// appended. The walk of the token along the cell chain, to the matched index, or to
// the entry count for a new or overflowing vertex, sets when an item is done, and a
// stalled output register holds the token at its cell until it drains. One item
// is in the search at a time, while a finished result waits in the output
// register. Coordinates compare as IEEE numbers: +0 equals -0, NaN matches
// nothing. start_mesh empties the table before its vertex is handled. When the
// table is full, a vertex that matches nothing returns index 0 with overflow set.
module vertex_dedup_indexer #(
	parameter int MAX_VERTICES = vdi_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = vdi_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [COORD_WIDTH-1:0]          coord_x,
	input  logic [COORD_WIDTH-1:0]          coord_y,
	input  logic [COORD_WIDTH-1:0]          coord_z,
	input  logic                            start_mesh,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [vdi_pkg::INDEX_WIDTH-1:0] weld_index,
	output logic                            is_new,
	output logic                            overflow
);
	import vdi_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	logic                   busy_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       cursor_q;
	logic [COORD_WIDTH-1:0] qx_q;
	logic [COORD_WIDTH-1:0] qy_q;
	logic [COORD_WIDTH-1:0] qz_q;
	logic                   out_valid_q;
	logic [INDEX_WIDTH-1:0] index_q;
	logic                   new_q;
	logic                   ovf_q;

	logic                   accept;
	logic                   at_end;
	logic                   full_at_end;
	logic                   hit_any;
	logic                   done;
	logic                   fin;
	logic [CNT_W+INDEX_WIDTH-1:0] cursor_ext;
	cell_ctrl_t             ctrl;
	logic [MAX_VERTICES:0]  tok_chain;
	logic [MAX_VERTICES-1:0] hit_vec;

	assign accept      = in_valid && !in_stall;
	assign in_stall    = busy_q;
	assign at_end      = busy_q && (cursor_q == count_q);
	assign full_at_end = at_end && (cursor_q == CNT_W'(MAX_VERTICES));
	assign hit_any     = |hit_vec;
	assign done        = busy_q && (at_end || hit_any);
	assign ctrl.at_end = at_end;
	assign ctrl.fin_ok = !out_valid_q || !out_stall;
	assign fin         = done && ctrl.fin_ok;
	assign cursor_ext  = {{INDEX_WIDTH{1'b0}}, cursor_q};
	assign tok_chain[0] = accept;

	genvar g;
	generate
		for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
			vdi_cell #(
				.COORD_WIDTH(COORD_WIDTH)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.tok_in (tok_chain[g]),
				.qx     (qx_q),
				.qy     (qy_q),
				.qz     (qz_q),
				.tok_out(tok_chain[g+1]),
				.hit    (hit_vec[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q   <= 1'b1;
				cursor_q <= '0;
				if (start_mesh) begin
					count_q <= '0;
				end
			end else if (fin) begin
				busy_q <= 1'b0;
				if (at_end && !full_at_end) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (busy_q && !done) begin
				cursor_q <= cursor_q + CNT_W'(1);
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
			qz_q <= coord_z;
		end
		if (fin) begin
			index_q <= full_at_end ? '0 : cursor_ext[INDEX_WIDTH-1:0];
			new_q   <= at_end && !full_at_end;
			ovf_q   <= full_at_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign weld_index   = index_q;
	assign is_new       = new_q;
	assign overflow     = ovf_q;

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell reports a hit");

	a_token_exit_full: assert property (@(posedge clk) disable iff (!arst_n)
		tok_chain[MAX_VERTICES] |-> count_q == CNT_W'(MAX_VERTICES))
		else $error("token left the chain with room in the table");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cursor_q <= count_q)
		else $error("search cursor passed the entry count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("entry count above table depth");

	a_hit_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hit_any |-> busy_q && !at_end)
		else $error("hit reported outside a search");

endmodule

>>> rtl/vdi_cell.sv
// One table cell: holds one stored vertex, compares the query and passes the search token on.
module vdi_cell #(
	parameter int COORD_WIDTH = vdi_pkg::COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vdi_pkg::cell_ctrl_t    ctrl,
	input  logic                   tok_in,
	input  logic [COORD_WIDTH-1:0] qx,
	input  logic [COORD_WIDTH-1:0] qy,
	input  logic [COORD_WIDTH-1:0] qz,
	output logic                   tok_out,
	output logic                   hit
);
	import vdi_pkg::*;

	localparam int EXP_BITS  = (COORD_WIDTH >= 64) ? 11 : 8;
	localparam int FRAC_BITS = COORD_WIDTH - 1 - EXP_BITS;

	logic                   tok_q;
	logic [COORD_WIDTH-1:0] x_q;
	logic [COORD_WIDTH-1:0] y_q;
	logic [COORD_WIDTH-1:0] z_q;
	logic                   match;
	logic                   stop;

	function automatic logic is_nan(input logic [COORD_WIDTH-1:0] w);
		return (&w[COORD_WIDTH-2:FRAC_BITS]) && (|w[FRAC_BITS-1:0]);
	endfunction

	function automatic logic is_zero(input logic [COORD_WIDTH-1:0] w);
		return ~|w[COORD_WIDTH-2:0];
	endfunction

	function automatic logic coord_eq(input logic [COORD_WIDTH-1:0] a,
			input logic [COORD_WIDTH-1:0] b);
		return !is_nan(a) && !is_nan(b) && ((is_zero(a) && is_zero(b)) || (a == b));
	endfunction

	assign match   = coord_eq(qx, x_q) && coord_eq(qy, y_q) && coord_eq(qz, z_q);
	assign hit     = tok_q && !ctrl.at_end && match;
	assign stop    = ctrl.at_end || match;
	assign tok_out = tok_q && !stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in || (tok_q && stop && !ctrl.fin_ok);
		end
	end

	// append the query at the end of the list
	always_ff @(posedge clk) begin
		if (tok_q && ctrl.at_end && ctrl.fin_ok) begin
			x_q <= qx;
			y_q <= qy;
			z_q <= qz;
		end
	end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for vertex_dedup_indexer: directed corner cases, then random meshes.
`timescale 1ns / 100ps

module testbench;

	localparam int NV = vdi_pkg::MAX_VERTICES_DEF;
	localparam int CW = vdi_pkg::COORD_WIDTH_DEF;
	localparam int IW = vdi_pkg::INDEX_WIDTH;
	localparam int RANDOM_ITEMS = 500;
	localparam int STALL_LIMIT = 4000;

	typedef logic [CW-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	typedef struct {
		logic [IW-1:0] index;
		logic          fresh;
		logic          full;
	} weld_result_t;

	class weld_scoreboard;
		coord_t       table_x [NV];
		coord_t       table_y [NV];
		coord_t       table_z [NV];
		int unsigned  entry_count;
		weld_result_t expected_welds [$];
		int           errors;
		int           n_vertices;
		int           n_meshes;
		int           n_new;
		int           n_matched;
		int           n_overflow;

		function new();
			entry_count = 0;
			errors = 0;
			n_vertices = 0;
			n_meshes = 0;
			n_new = 0;
			n_matched = 0;
			n_overflow = 0;
		endfunction

		static function bit coord_is_nan(coord_t w);
			return (w[CW-2 -: 8] == 8'hFF) && (w[CW-10:0] != '0);
		endfunction

		static function bit coord_equal(coord_t a, coord_t b);
			if (coord_is_nan(a) || coord_is_nan(b))
				return 1'b0;
			if (a[CW-2:0] == '0 && b[CW-2:0] == '0)
				return 1'b1;
			return a == b;
		endfunction

		function void note_vertex(coord_t x, coord_t y, coord_t z, logic start);
			weld_result_t r;
			bit found;
			int unsigned k;
			found = 1'b0;
			r.index = '0;
			r.fresh = 1'b0;
			r.full = 1'b0;
			n_vertices++;
			if (start) begin
				entry_count = 0;
				n_meshes++;
			end
			for (k = 0; k < entry_count && !found; k++) begin
				if (coord_equal(x, table_x[k]) && coord_equal(y, table_y[k]) &&
				    coord_equal(z, table_z[k])) begin
					r.index = k[IW-1:0];
					found = 1'b1;
				end
			end
			if (found) begin
				n_matched++;
			end else if (entry_count < NV) begin
				table_x[entry_count] = x;
				table_y[entry_count] = y;
				table_z[entry_count] = z;
				r.index = entry_count[IW-1:0];
				r.fresh = 1'b1;
				entry_count++;
				n_new++;
			end else begin
				r.full = 1'b1;
				n_overflow++;
			end
			expected_welds.push_back(r);
		endfunction

		function void check_result(logic [IW-1:0] index, logic fresh, logic full);
			weld_result_t r;
			if (expected_welds.size() == 0) begin
				$error("result beat with nothing expected: index %0d", index);
				errors++;
				return;
			end
			r = expected_welds.pop_front();
			if (index !== r.index) begin
				$error("weld_index: expected %0d, got %0d", r.index, index);
				errors++;
			end
			if (fresh !== r.fresh) begin
				$error("is_new: expected %0b, got %0b", r.fresh, fresh);
				errors++;
			end
			if (full !== r.full) begin
				$error("overflow: expected %0b, got %0b", r.full, full);
				errors++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	coord_t        coord_x;
	coord_t        coord_y;
	coord_t        coord_z;
	logic          start_mesh;
	logic          out_valid;
	logic          out_stall;
	logic [IW-1:0] weld_index;
	logic          is_new;
	logic          overflow;

	weld_scoreboard board;
	bit             no_idle;
	int             quiet_cycles;

	vertex_dedup_indexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.start_mesh   (start_mesh),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.weld_index   (weld_index),
		.is_new       (is_new),
		.overflow     (overflow)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		start_mesh = 1'b0;
		out_stall = 1'b0;
		no_idle = 1'b0;
		quiet_cycles = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_vertex(coord_x, coord_y, coord_z, start_mesh);
			if (out_valid && !out_stall)
				board.check_result(weld_index, is_new, overflow);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("vertex_dedup_indexer regression: fail");
				$finish;
			end
		end
	end

	// hold off the result side for a random count per beat
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			out_stall <= (hold != 0);
			if (hold != 0) begin
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic drive_vertex(vertex_t v, logic start);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		coord_x <= v.x;
		coord_y <= v.y;
		coord_z <= v.z;
		start_mesh <= start;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom) | 23'd1};
			3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic vertex_t flip_zeros(vertex_t v);
		vertex_t f;
		f = v;
		if (f.x[CW-2:0] == '0 && $urandom_range(0, 1) == 1) f.x[CW-1] = ~f.x[CW-1];
		if (f.y[CW-2:0] == '0 && $urandom_range(0, 1) == 1) f.y[CW-1] = ~f.y[CW-1];
		if (f.z[CW-2:0] == '0 && $urandom_range(0, 1) == 1) f.z[CW-1] = ~f.z[CW-1];
		return f;
	endfunction

	initial begin
		vertex_t mesh [$];
		vertex_t pool [$];
		vertex_t v;
		int sent;
		int extra;
		int pool_n;
		int corners;
		int bitpos;
		logic first_start;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zeros of both signs, NaN, infinities, denormals, mesh restarts
		drive_vertex('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
		drive_vertex('{32'h8000_0000, 32'h0000_0000, 32'h8000_0000}, 1'b0);
		drive_vertex('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0);
		drive_vertex('{32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
		drive_vertex('{32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
		drive_vertex('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
		drive_vertex('{32'h0000_0000, 32'h7F80_0001, 32'h0000_0000}, 1'b0);
		drive_vertex('{32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}, 1'b0);
		drive_vertex('{32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}, 1'b0);
		drive_vertex('{32'h0000_0001, 32'h8000_0001, 32'h3F80_0000}, 1'b0);
		drive_vertex('{32'h8000_0001, 32'h8000_0001, 32'h3F80_0000}, 1'b0);
		drive_vertex('{32'h0000_0000, 32'h8000_0000, 32'h0000_0000}, 1'b0);
		drive_vertex('{32'h0000_0000, 32'h0000_0000, 32'h0000_0001}, 1'b0);
		drive_vertex('{32'h0000_0001, 32'h8000_0001, 32'h3F80_0000}, 1'b0);
		drive_vertex('{32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000}, 1'b1);
		drive_vertex('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);
		drive_vertex('{32'h3F80_0000, 32'hBF80_0000, 32'h8000_0000}, 1'b0);
		drive_vertex('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1);
		drive_vertex('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1);
		drive_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}, 1'b0);

		// fill one mesh past the table size
		sent = 0;
		extra = 0;
		no_idle = 1'b0;
		v = '{CW'($urandom), CW'($urandom), '0};
		mesh.push_back(v);
		drive_vertex(v, 1'b1);
		sent++;
		while (extra < 24) begin
			if (mesh.size() < NV && $urandom_range(0, 3) != 0) begin
				v = '{CW'($urandom), CW'($urandom), CW'(mesh.size())};
				mesh.push_back(v);
			end else if (mesh.size() < NV) begin
				v = flip_zeros(mesh[$urandom_range(0, mesh.size() - 1)]);
			end else begin
				extra++;
				case ($urandom_range(0, 2))
					0: v = '{CW'($urandom), CW'($urandom), CW'($urandom) | 32'h0001_0000};
					1: v = mesh[mesh.size() - 1];
					default: v = flip_zeros(mesh[$urandom_range(0, mesh.size() - 1)]);
				endcase
			end
			drive_vertex(v, 1'b0);
			sent++;
		end

		// small meshes from a vertex pool, with near misses and noise
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			pool.delete();
			pool_n = $urandom_range(2, 12);
			repeat (pool_n) pool.push_back('{rand_coord(), rand_coord(), rand_coord()});
			corners = $urandom_range(4, 40);
			first_start = ($urandom_range(0, 7) != 0);
			for (int c = 0; c < corners; c++) begin
				v = pool[$urandom_range(0, pool_n - 1)];
				case ($urandom_range(0, 15))
					12, 13: begin
						bitpos = $urandom_range(0, CW - 1);
						case ($urandom_range(0, 2))
							0: v.x[bitpos] = ~v.x[bitpos];
							1: v.y[bitpos] = ~v.y[bitpos];
							default: v.z[bitpos] = ~v.z[bitpos];
						endcase
					end
					14, 15: v = '{CW'($urandom), CW'($urandom), CW'($urandom)};
					default: v = flip_zeros(v);
				endcase
				drive_vertex(v, (c == 0) ? first_start : ($urandom_range(0, 49) == 0));
				sent++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_welds.size() != 0) @(posedge clk);
		repeat (NV + 16) @(posedge clk);
		if (board.expected_welds.size() != 0) begin
			$error("%0d expected results never arrived", board.expected_welds.size());
			board.errors++;
		end

		$display("checked %0d vertex beats over %0d mesh restarts", board.n_vertices,
			board.n_meshes);
		$display("outcomes: %0d appended, %0d matched, %0d rejected on a full table",
			board.n_new, board.n_matched, board.n_overflow);
		if (board.errors == 0) begin
			$display("vertex_dedup_indexer regression: pass");
		end else begin
			$display("vertex_dedup_indexer regression: fail");
		end
		$finish;
	end

endmodule
